// File: hw/rtl/pa3s_pkg.sv
// Shared constants and types of the packed 17-bit 3D array store.
package pa3s_pkg;

  localparam int unsigned ELEM_BITS  = 17;
  localparam int unsigned COORD_W    = 4;
  localparam int unsigned WVAL_W     = 32;
  localparam int unsigned SIZE_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned OFFS_W     = 4;

  localparam logic [ELEM_BITS-1:0] ELEM_MAX   = 17'h1ffff;
  localparam logic [SIZE_W-1:0]    SIZE_RESET = 5'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Position of an element inside the 32-bit window of two adjacent words.
  typedef struct packed {
    logic              swap;
    logic [OFFS_W-1:0] offset;
  } win_ctl_t;

endpackage

// File: hw/rtl/pa3s_if.sv
// Valid/ready channel interfaces for the request and response items.
interface pa3s_in_if import pa3s_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [COORD_W-1:0] z_coord;
  logic [WVAL_W-1:0]  write_value;

  modport source (output valid, op, x_coord, y_coord, z_coord, write_value, input ready);
  modport sink   (input valid, op, x_coord, y_coord, z_coord, write_value, output ready);
endinterface

interface pa3s_out_if import pa3s_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELEM_BITS-1:0] read_value;
  logic                 coord_error;

  modport source (output valid, read_value, coord_error, input ready);
  modport sink   (input valid, read_value, coord_error, output ready);
endinterface

// File: hw/rtl/pa3s_bank.sv
// Single-port synchronous memory bank with a registered read port.
module pa3s_bank #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pa3s_window.sv
// Extracts and inserts one 17-bit element within a window of two adjacent words.
module pa3s_window import pa3s_pkg::*; (
  input  win_ctl_t             ctl_i,
  input  logic [WORD_W-1:0]    even_i,
  input  logic [WORD_W-1:0]    odd_i,
  input  logic [ELEM_BITS-1:0] wval_i,
  output logic [ELEM_BITS-1:0] rd_val_o,
  output logic [WORD_W-1:0]    even_o,
  output logic [WORD_W-1:0]    odd_o
);

  logic [2*WORD_W-1:0] win;
  logic [2*WORD_W-1:0] mask;
  logic [2*WORD_W-1:0] new_win;
  logic [OFFS_W-1:0]   sh;

  // The element's first bit sits at window bit 31 - offset, so its least
  // significant bit sits at 15 - offset.
  assign win      = ctl_i.swap ? {odd_i, even_i} : {even_i, odd_i};
  assign sh       = ~ctl_i.offset;
  assign rd_val_o = ELEM_BITS'(win >> sh);
  assign mask     = (2*WORD_W)'(ELEM_MAX) << sh;
  assign new_win  = (win & ~mask) | ((2*WORD_W)'(wval_i) << sh);
  assign even_o   = ctl_i.swap ? new_win[WORD_W-1:0] : new_win[2*WORD_W-1:WORD_W];
  assign odd_o    = ctl_i.swap ? new_win[2*WORD_W-1:WORD_W] : new_win[WORD_W-1:0];

endmodule

// File: hw/rtl/packed_17bit_3d_array_store_unit.sv
// Top level of the packed 17-bit 3D array store: sequencer, address path and memory banks.
//
// The block holds a three-dimensional array of unsigned 17-bit elements packed
// without gaps, most significant bit first, element (x,y,z) starting at bit
// 17*(sx*sy*z + sx*y + x). Each request item reads an element, or writes one
// with its value saturated to 0x1ffff, and yields exactly one response item;
// a coordinate not below its size (sizes above MAX_DIM count as MAX_DIM, a
// size of zero rejects everything) sets coord_error, leaves the store as it
// is and returns zero. The bits live in two 16-bit banks holding the even and
// odd words, so any element lies in one word of each and is read and written
// back through a single port per bank. An accepted item goes through the row
// product, the element index, the bank read, the modify and write-back, and
// the output register load, which waits while a response there is untaken;
// an item with a coordinate error skips to that load. One item is in work
// at a time, so the next item is taken in the cycle after the response is
// loaded; a response waiting in the output register does not hold back the
// next request, only the loading of the one after it. After reset the banks
// are zeroed one row a cycle, through all 2177 rows of a bank at MAX_DIM of
// 16, before the first request is taken. Size registers may be written at
// any time the block is idle, also during that clearing.
module packed_17bit_3d_array_store_unit import pa3s_pkg::*; #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  pa3s_in_if.sink              in_if,
  pa3s_out_if.source           out_if
);

  // A size register holds at most 31, so no larger extent is reachable.
  localparam int unsigned EFF_MAX    = (MAX_DIM < 31) ? MAX_DIM : 31;
  localparam int unsigned ELEMS      = EFF_MAX * EFF_MAX * EFF_MAX;
  localparam int unsigned TOTAL_BITS = ELEMS * ELEM_BITS;
  // One spare word so that the word after the last element always exists.
  localparam int unsigned WORDS      = (TOTAL_BITS + WORD_W - 1) / WORD_W + 1;
  localparam int unsigned ROWS       = (WORDS + 1) / 2;
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned POS_W      = $clog2(TOTAL_BITS);
  localparam int unsigned T_W        = 10;
  localparam int unsigned IDX_W      = 15;
  localparam int unsigned PROD_W     = 20;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ADDR  = 6'b000100,
    S_READ  = 6'b001000,
    S_MOD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [ROW_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic [SIZE_W-1:0]    size_x_q, size_y_q, size_z_q;
  logic [SIZE_W-1:0]    sx_eff, sy_eff, sz_eff;

  logic                 op_q, op_d;
  logic [COORD_W-1:0]   x_q, x_d;
  logic [ELEM_BITS-1:0] wval_q, wval_d;
  logic [T_W-1:0]       t_q, t_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 err_q, err_d;
  logic [ELEM_BITS-1:0] res_q, res_d;

  logic                 out_valid_q, out_valid_d;
  logic [ELEM_BITS-1:0] out_val_q, out_val_d;
  logic                 out_err_q, out_err_d;

  logic                 in_fire;
  logic                 coord_bad;
  logic [IDX_W-1:0]     idx;
  logic [POS_W-4-1:0]   word_idx;
  logic [ROW_W-1:0]     row_even, row_odd;
  logic [ROW_W-1:0]     addr_even, addr_odd;
  logic                 bank_we, bank_re;
  logic [WORD_W-1:0]    rd_even, rd_odd, wr_even, wr_odd;
  logic [ELEM_BITS-1:0] elem_val;
  win_ctl_t             win_ctl;

  // Sizes above the array's extent address as the extent itself.
  assign sx_eff = (32'(size_x_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_x_q;
  assign sy_eff = (32'(size_y_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_y_q;
  assign sz_eff = (32'(size_z_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_z_q;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  assign coord_bad = (SIZE_W'(in_if.x_coord) >= sx_eff) ||
                     (SIZE_W'(in_if.y_coord) >= sy_eff) ||
                     (SIZE_W'(in_if.z_coord) >= sz_eff);

  // Element index from the registered row product, then times 17 as shift and add.
  assign idx   = IDX_W'(IDX_W'(t_q) * IDX_W'(sx_eff) + IDX_W'(x_q));
  assign pos_d = POS_W'(PROD_W'({idx, 4'b0000}) + PROD_W'(idx));

  // Word w and word w+1 always fall in different banks.
  assign word_idx       = pos_q[POS_W-1:4];
  assign row_odd        = ROW_W'(word_idx >> 1);
  assign row_even       = ROW_W'((word_idx >> 1) + (POS_W-4)'(word_idx[0]));
  assign win_ctl.swap   = word_idx[0];
  assign win_ctl.offset = pos_q[3:0];

  assign addr_even = (state_q == S_CLEAR) ? clr_cnt_q : row_even;
  assign addr_odd  = (state_q == S_CLEAR) ? clr_cnt_q : row_odd;
  assign bank_re   = (state_q == S_READ);
  assign bank_we   = (state_q == S_CLEAR) || ((state_q == S_MOD) && (op_q == OP_WRITE));

  pa3s_bank #(
    .DEPTH (ROWS),
    .WIDTH (WORD_W)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (bank_we),
    .re_i    (bank_re),
    .addr_i  (addr_even),
    .wdata_i ((state_q == S_CLEAR) ? '0 : wr_even),
    .rdata_o (rd_even)
  );

  pa3s_bank #(
    .DEPTH (ROWS),
    .WIDTH (WORD_W)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (bank_we),
    .re_i    (bank_re),
    .addr_i  (addr_odd),
    .wdata_i ((state_q == S_CLEAR) ? '0 : wr_odd),
    .rdata_o (rd_odd)
  );

  pa3s_window u_window (
    .ctl_i    (win_ctl),
    .even_i   (rd_even),
    .odd_i    (rd_odd),
    .wval_i   (wval_q),
    .rd_val_o (elem_val),
    .even_o   (wr_even),
    .odd_o    (wr_odd)
  );

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    op_d        = op_q;
    x_d         = x_q;
    wval_d      = wval_q;
    t_d         = t_q;
    err_d       = err_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_val_d   = out_val_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ROW_W'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_d   = in_if.op;
          x_d    = in_if.x_coord;
          wval_d = (in_if.write_value > WVAL_W'(ELEM_MAX)) ? ELEM_MAX
                                                           : in_if.write_value[ELEM_BITS-1:0];
          t_d    = T_W'(T_W'(in_if.z_coord) * T_W'(sy_eff) + T_W'(in_if.y_coord));
          err_d  = coord_bad;
          res_d  = '0;
          state_d = coord_bad ? S_DONE : S_ADDR;
        end
      end
      S_ADDR: begin
        state_d = S_READ;
      end
      S_READ: begin
        state_d = S_MOD;
      end
      S_MOD: begin
        res_d   = (op_q == OP_WRITE) ? '0 : elem_val;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_q;
          out_err_d   = err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      size_x_q    <= SIZE_RESET;
      size_y_q    <= SIZE_RESET;
      size_z_q    <= SIZE_RESET;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SIZE_X: size_x_q <= cfg_data_i;
          REG_SIZE_Y: size_y_q <= cfg_data_i;
          REG_SIZE_Z: size_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    x_q       <= x_d;
    wval_q    <= wval_d;
    t_q       <= t_d;
    pos_q     <= pos_d;
    err_q     <= err_d;
    res_q     <= res_d;
    out_val_q <= out_val_d;
    out_err_q <= out_err_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.read_value  = out_val_q;
  assign out_if.coord_error = out_err_q;

endmodule

// File: hw/rtl/pa3s_checker.sv
// Port-level assertions for the array store, bound to its top level.
module pa3s_checker import pa3s_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [ELEM_BITS-1:0] read_value_i,
  input logic                 coord_error_i
);

  // A response that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response withdrawn while stalled");

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(read_value_i) && $stable(coord_error_i))
    else $error("stalled response changed");

  // A rejected access always reports a zero element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && coord_error_i |-> read_value_i == '0)
    else $error("coordinate error with non-zero value");

  // Only one item is in work, so requests are never taken on adjacent cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous item in work");

endmodule

bind packed_17bit_3d_array_store_unit pa3s_checker u_pa3s_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .read_value_i  (out_if.read_value),
  .coord_error_i (out_if.coord_error)
);
